FILE: rtl/sqimg_pkg.sv
// Shared constants and types for the square image flip/rotate block.
`default_nettype none
package sqimg_pkg;

    localparam int SIDE       = 32;
    localparam int PIXEL_BITS = 8;

    localparam int AREA    = SIDE * SIDE;
    localparam int COORD_W = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int ADDR_W  = $clog2(AREA);
    localparam int PIX_W   = 8;
    localparam int STORE_W = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
    localparam int MODE_W  = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRANS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_CW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_CC = 3'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // One classified operation for the memory side.
    typedef struct packed {
        logic               is_write;
        logic [ADDR_W-1:0]  addr;
        logic [STORE_W-1:0] pixel;
        logic               last;
        logic               not_ready;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/sqimg_front.sv
// Front end: accepts transactions, tracks frame positions, computes source addresses.
`default_nettype none
module sqimg_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [sqimg_pkg::MODE_W-1:0] i_cfg_mode,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_action,
    input  wire logic [sqimg_pkg::PIX_W-1:0] i_pixel_in,
    input  wire logic                   i_q_full,
    output logic                        o_push,
    output sqimg_pkg::t_cmd             o_cmd
);
    import sqimg_pkg::*;

    localparam logic [COORD_W-1:0] SIDE_M1 = COORD_W'(SIDE - 1);
    localparam logic [ADDR_W-1:0]  AREA_M1 = ADDR_W'(AREA - 1);

    logic [MODE_W-1:0]  r_mode;
    logic [ADDR_W-1:0]  r_wpos, n_wpos;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_col, n_col;
    logic               r_ready, n_ready;

    logic [COORD_W-1:0] src_row, src_col;
    logic               rd_last;

    assign o_push = i_in_valid && !i_q_full;

    always_comb begin
        case (r_mode)
            MODE_FLIP_H: begin src_row = r_row;            src_col = SIDE_M1 - r_col; end
            MODE_FLIP_V: begin src_row = SIDE_M1 - r_row;  src_col = r_col;           end
            MODE_TRANS:  begin src_row = r_col;            src_col = r_row;           end
            MODE_ROT_CW: begin src_row = SIDE_M1 - r_col;  src_col = r_row;           end
            MODE_ROT_CC: begin src_row = r_col;            src_col = SIDE_M1 - r_row; end
            default:     begin src_row = r_row;            src_col = r_col;           end
        endcase
    end

    assign rd_last = (r_row == SIDE_M1) && (r_col == SIDE_M1);

    always_comb begin
        o_cmd.is_write  = (i_action == ACT_WRITE);
        o_cmd.pixel     = i_pixel_in[STORE_W-1:0];
        o_cmd.last      = 1'b0;
        o_cmd.not_ready = 1'b0;
        if (i_action == ACT_WRITE) begin
            o_cmd.addr = r_wpos;
        end else begin
            o_cmd.addr = ADDR_W'(src_row) * ADDR_W'(SIDE) + ADDR_W'(src_col);
            o_cmd.last      = r_ready && rd_last;
            o_cmd.not_ready = !r_ready;
        end
    end

    always_comb begin
        n_wpos  = r_wpos;
        n_row   = r_row;
        n_col   = r_col;
        n_ready = r_ready;
        if (o_push) begin
            if (i_action == ACT_WRITE) begin
                if (r_wpos == AREA_M1) begin
                    n_wpos  = '0;
                    n_ready = 1'b1;
                end else begin
                    n_wpos = r_wpos + 1'b1;
                end
            end else if (r_ready) begin
                if (r_col == SIDE_M1) begin
                    n_col = '0;
                    if (r_row == SIDE_M1) begin
                        n_row   = '0;
                        n_ready = 1'b0;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FLIP_H;
            r_wpos  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ready <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_mode;
            end
            r_wpos  <= n_wpos;
            r_row   <= n_row;
            r_col   <= n_col;
            r_ready <= n_ready;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sqimg_queue.sv
// Small command queue between the front end and the memory side.
`default_nettype none
module sqimg_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sqimg_pkg::t_cmd i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output sqimg_pkg::t_cmd      o_cmd
);
    import sqimg_pkg::*;

    t_cmd                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sqimg_back.sv
// Back end: frame store, registered reads and the output register.
`default_nettype none
module sqimg_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire sqimg_pkg::t_cmd      i_cmd,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [sqimg_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_last_pixel,
    output logic                      o_not_ready
);
    import sqimg_pkg::*;

    logic [STORE_W-1:0] r_mem [AREA];
    logic [STORE_W-1:0] r_rd;
    logic               r_valid;
    logic               r_last;
    logic               r_nr;
    logic               pop_rd;
    logic [PIX_W-1:0]   pix_ext;

    // Writes drain even while a result waits; reads need the output slot.
    assign o_pop  = i_q_valid && (i_cmd.is_write || !r_valid || !i_out_stall);
    assign pop_rd = o_pop && !i_cmd.is_write;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_write) begin
            r_mem[i_cmd.addr] <= i_cmd.pixel;
        end
        if (pop_rd && !i_cmd.not_ready) begin
            r_rd <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_nr    <= 1'b0;
        end else if (pop_rd) begin
            r_valid <= 1'b1;
            r_last  <= i_cmd.last;
            r_nr    <= i_cmd.not_ready;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_comb begin
        pix_ext = '0;
        pix_ext[STORE_W-1:0] = r_rd;
    end

    assign o_out_valid  = r_valid;
    assign o_pixel_out  = r_nr ? '0 : pix_ext;
    assign o_last_pixel = r_last;
    assign o_not_ready  = r_nr;

endmodule
`default_nettype wire

FILE: rtl/square_image_flip_rotate_top.sv
// Top level of the square image flip/rotate block.
// Stores a SIDE x SIDE frame written in raster order and returns it, one pixel per read
// transaction, flipped, transposed or rotated as the mode register selects. Both write and
// read transactions are taken at one per clock while the command queue is not full; the
// single-port frame store handles one access per cycle. A read result is shown in the cycle
// after the command leaves the four-entry command queue. Writes keep draining while a result
// is held by output stall; reads wait for the output register. No clearing pass follows
// reset: the store is only read after a full frame has been written.
`default_nettype none
module square_image_flip_rotate_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sqimg_pkg::MODE_W-1:0]  i_cfg_mode,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [sqimg_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [sqimg_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                               o_last_pixel,
    output logic                               o_not_ready
);
    import sqimg_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    sqimg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_mode  (i_cfg_mode),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_pixel_in  (i_pixel_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    sqimg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    sqimg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_last_pixel (o_last_pixel),
        .o_not_ready  (o_not_ready)
    );

endmodule
`default_nettype wire

FILE: rtl/sqimg_checker.sv
// Port-level checks for the square image flip/rotate block, bound to the top level.
`default_nettype none
module sqimg_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [sqimg_pkg::PIX_W-1:0]   o_pixel_out,
    input wire logic                          o_last_pixel,
    input wire logic                          o_not_ready
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_out)
            && $stable(o_last_pixel) && $stable(o_not_ready))
        else $error("output transaction changed while stalled");

    a_nr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_not_ready |-> o_pixel_out == '0 && !o_last_pixel)
        else $error("not-ready result carries data or last flag");

    // Nothing comes out right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall right after reset");

    // No result is valid directly after reset is released.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result without accepted transaction");

endmodule

bind square_image_flip_rotate_top sqimg_checker u_sqimg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pixel_out  (o_pixel_out),
    .o_last_pixel (o_last_pixel),
    .o_not_ready  (o_not_ready)
);
`default_nettype wire
